// ===== rtl/core/hrlf_pkg.sv =====
// hrlf_pkg: types and constants shared by the request line fingerprint unit
// beat structs, feature vector type, character codes and feature/code values
// no dependencies
`default_nettype none

package hrlf_pkg;

  localparam int unsigned FEATURE_COUNT = 14;
  localparam int unsigned NUM_COUNTS    = 11;
  localparam int unsigned VALUE_W       = 16;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       end_of_header;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         feature_index;
    logic [VALUE_W-1:0] feature_value;
    logic               last_feature;
  } out_beat_t;

  typedef logic [FEATURE_COUNT-1:0][VALUE_W-1:0] feat_vec_t;

  localparam logic [3:0] LAST_IDX = 4'(FEATURE_COUNT - 1);

  // feature slots
  localparam int unsigned FI_METHOD  = 0;
  localparam int unsigned FI_VERSION = 1;
  localparam int unsigned FI_LENGTH  = 2;
  localparam int unsigned FI_COUNTS  = 3;

  // counter slots, in feature order after the length
  localparam int unsigned C_VARS = 0;
  localparam int unsigned C_PCT  = 1;
  localparam int unsigned C_APOS = 2;
  localparam int unsigned C_PLUS = 3;
  localparam int unsigned C_DDOT = 4;
  localparam int unsigned C_BSL  = 5;
  localparam int unsigned C_OPAR = 6;
  localparam int unsigned C_CPAR = 7;
  localparam int unsigned C_DSL  = 8;
  localparam int unsigned C_LT   = 9;
  localparam int unsigned C_GT   = 10;

  // method and version codes
  localparam logic [3:0] METH_GET  = 4'd1;
  localparam logic [3:0] METH_POST = 4'd2;
  localparam logic [3:0] METH_HEAD = 4'd4;
  localparam logic [3:0] METH_NONE = 4'd8;
  localparam logic [3:0] VER_X9    = 4'd1;
  localparam logic [3:0] VER_X0    = 4'd2;
  localparam logic [3:0] VER_X1    = 4'd4;
  localparam logic [3:0] VER_NONE  = 4'd8;

  // character codes
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_AMP   = 8'd38;
  localparam logic [7:0] CH_APOS  = 8'd39;
  localparam logic [7:0] CH_OPAR  = 8'd40;
  localparam logic [7:0] CH_CPAR  = 8'd41;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_1     = 8'd49;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_QMARK = 8'd63;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_D     = 8'd68;
  localparam logic [7:0] CH_E     = 8'd69;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_H     = 8'd72;
  localparam logic [7:0] CH_O     = 8'd79;
  localparam logic [7:0] CH_P     = 8'd80;
  localparam logic [7:0] CH_S     = 8'd83;
  localparam logic [7:0] CH_T     = 8'd84;
  localparam logic [7:0] CH_BSL   = 8'd92;

endpackage

`default_nettype wire

// ===== rtl/core/hrlf_scan.sv =====
// hrlf_scan: input register and per-byte scan of the request line
// keeps the lookahead window, method/version detection and saturating counters
// depends on hrlf_pkg
`default_nettype none

module hrlf_scan import hrlf_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_beat_i,
  output logic           snap_valid_o,
  input  wire logic      snap_ready_i,
  output feat_vec_t      snap_o
);

  localparam int unsigned CNT_W = (COUNT_WIDTH < VALUE_W) ? COUNT_WIDTH : VALUE_W;

  logic            s1_valid_q;
  in_beat_t        s1_beat_q;
  logic            s1_adv;

  logic            line_open_q, line_open_d;
  logic [3:0]      method_code_q, method_code_d;
  logic            method_found_q, method_found_d;
  logic [3:0]      version_code_q, version_code_d;
  logic            version_found_q, version_found_d;
  logic            query_seen_q, query_seen_d;
  logic [7:0]      pend_q [3];
  logic [7:0]      pend_d [3];
  logic [1:0]      pend_cnt_q, pend_cnt_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] cnt_q [NUM_COUNTS];
  logic [CNT_W-1:0] cnt_d [NUM_COUNTS];

  // values after this beat, before the end-of-header clear
  logic [3:0]      m_code, v_code;
  logic            m_found, v_found, q_seen;
  logic [CNT_W-1:0] len_upd;
  logic [CNT_W-1:0] cnt_upd [NUM_COUNTS];
  logic [2:0]      hits [NUM_COUNTS];

  logic [7:0]      seq [4];
  logic [7:0]      ext [7];
  logic [2:0]      seq_len;
  logic            crlf, appended, flush;
  logic [3:0]      pos_en;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [2:0] k);
    logic [CNT_W+2:0] sum;
    sum = {3'b000, a} + (CNT_W+3)'(k);
    if (sum > {3'b000, {CNT_W{1'b1}}}) return {CNT_W{1'b1}};
    return sum[CNT_W-1:0];
  endfunction

  assign s1_adv     = s1_valid_q && (!s1_beat_q.end_of_header || snap_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign snap_valid_o = s1_valid_q && s1_beat_q.end_of_header;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_beat_q <= in_beat_i;
    end
  end

  // window of line bytes: pending bytes first, then the new byte
  always_comb begin
    crlf     = (s1_beat_q.header_byte == CH_CR) || (s1_beat_q.header_byte == CH_LF);
    appended = line_open_q && !crlf;
    flush    = line_open_q && (crlf || s1_beat_q.end_of_header);
    seq_len  = {1'b0, pend_cnt_q} + {2'b00, appended};
    for (int i = 0; i < 4; i++) begin
      seq[i] = (2'(i) < pend_cnt_q && i < 3) ? pend_q[(i < 3) ? i : 2]
                                             : s1_beat_q.header_byte;
    end
    for (int j = 0; j < 7; j++) begin
      ext[j] = (j < 4) ? seq[(j < 4) ? j : 0] : 8'h00;
    end
    for (int i = 0; i < 4; i++) begin
      pos_en[i] = flush ? (3'(i) < seq_len) : ((i == 0) && (seq_len == 3'd4));
    end
  end

  // evaluate up to four positions, earliest first
  always_comb begin
    logic [7:0] c, v1, v2, v3;
    logic [2:0] n;
    m_code  = method_code_q;
    m_found = method_found_q;
    v_code  = version_code_q;
    v_found = version_found_q;
    q_seen  = query_seen_q;
    for (int k = 0; k < NUM_COUNTS; k++) hits[k] = 3'd0;
    for (int i = 0; i < 4; i++) begin
      c  = ext[i];
      v1 = ext[i+1];
      v2 = ext[i+2];
      v3 = ext[i+3];
      n  = seq_len - 3'(i);
      if (pos_en[i]) begin
        if (!v_found && n >= 3'd3 && (c == CH_0 || c == CH_1) && v1 == CH_DOT) begin
          if (v2 == CH_0) begin
            v_code = VER_X0; v_found = 1'b1;
          end else if (v2 == CH_9) begin
            v_code = VER_X9; v_found = 1'b1;
          end else if (v2 == CH_1) begin
            v_code = VER_X1; v_found = 1'b1;
          end
        end
        if (!m_found) begin
          if (n >= 3'd3 && c == CH_G && v1 == CH_E && v2 == CH_T) begin
            m_code = METH_GET; m_found = 1'b1;
          end else if (n >= 3'd4 && c == CH_H && v1 == CH_E && v2 == CH_A && v3 == CH_D) begin
            m_code = METH_HEAD; m_found = 1'b1;
          end else if (n >= 3'd4 && c == CH_P && v1 == CH_O && v2 == CH_S && v3 == CH_T) begin
            m_code = METH_POST; m_found = 1'b1;
          end
        end
        if (n >= 3'd2 && c == CH_DOT && v1 == CH_DOT) hits[C_DDOT] = hits[C_DDOT] + 3'd1;
        if (n >= 3'd2 && c == CH_SLASH && v1 == CH_SLASH) hits[C_DSL] = hits[C_DSL] + 3'd1;
        case (c)
          CH_QMARK: q_seen = 1'b1;
          CH_PCT:   hits[C_PCT]  = hits[C_PCT]  + 3'd1;
          CH_AMP:   if (q_seen) hits[C_VARS] = hits[C_VARS] + 3'd1;
          CH_APOS:  hits[C_APOS] = hits[C_APOS] + 3'd1;
          CH_PLUS:  hits[C_PLUS] = hits[C_PLUS] + 3'd1;
          CH_OPAR:  hits[C_OPAR] = hits[C_OPAR] + 3'd1;
          CH_CPAR:  hits[C_CPAR] = hits[C_CPAR] + 3'd1;
          CH_LT:    hits[C_LT]   = hits[C_LT]   + 3'd1;
          CH_GT:    hits[C_GT]   = hits[C_GT]   + 3'd1;
          CH_BSL:   hits[C_BSL]  = hits[C_BSL]  + 3'd1;
          default:  ;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    len_upd = (len_q == {CNT_W{1'b1}}) ? len_q : len_q + CNT_W'(1);
    for (int k = 0; k < NUM_COUNTS; k++) cnt_upd[k] = sat_add(cnt_q[k], hits[k]);

    line_open_d     = line_open_q;
    method_code_d   = method_code_q;
    method_found_d  = method_found_q;
    version_code_d  = version_code_q;
    version_found_d = version_found_q;
    query_seen_d    = query_seen_q;
    pend_d          = pend_q;
    pend_cnt_d      = pend_cnt_q;
    len_d           = len_q;
    cnt_d           = cnt_q;

    if (s1_adv) begin
      if (s1_beat_q.end_of_header) begin
        line_open_d     = 1'b1;
        method_code_d   = METH_NONE;
        method_found_d  = 1'b0;
        version_code_d  = VER_NONE;
        version_found_d = 1'b0;
        query_seen_d    = 1'b0;
        pend_cnt_d      = 2'd0;
        len_d           = '0;
        for (int k = 0; k < NUM_COUNTS; k++) cnt_d[k] = '0;
      end else begin
        line_open_d     = line_open_q && !crlf;
        method_code_d   = m_code;
        method_found_d  = m_found;
        version_code_d  = v_code;
        version_found_d = v_found;
        query_seen_d    = q_seen;
        len_d           = len_upd;
        cnt_d           = cnt_upd;
        if (flush) begin
          pend_cnt_d = 2'd0;
        end else if (seq_len == 3'd4) begin
          pend_d[0]  = seq[1];
          pend_d[1]  = seq[2];
          pend_d[2]  = seq[3];
          pend_cnt_d = 2'd3;
        end else begin
          pend_d[0]  = seq[0];
          pend_d[1]  = seq[1];
          pend_d[2]  = seq[2];
          pend_cnt_d = seq_len[1:0];
        end
      end
    end
  end

  always_comb begin
    snap_o[FI_METHOD]  = VALUE_W'(m_code);
    snap_o[FI_VERSION] = VALUE_W'(v_code);
    snap_o[FI_LENGTH]  = VALUE_W'(len_upd);
    for (int k = 0; k < NUM_COUNTS; k++) snap_o[FI_COUNTS + k] = VALUE_W'(cnt_upd[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_open_q     <= 1'b1;
      method_code_q   <= METH_NONE;
      method_found_q  <= 1'b0;
      version_code_q  <= VER_NONE;
      version_found_q <= 1'b0;
      query_seen_q    <= 1'b0;
      pend_cnt_q      <= 2'd0;
      len_q           <= '0;
      for (int k = 0; k < NUM_COUNTS; k++) cnt_q[k] <= '0;
    end else begin
      line_open_q     <= line_open_d;
      method_code_q   <= method_code_d;
      method_found_q  <= method_found_d;
      version_code_q  <= version_code_d;
      version_found_q <= version_found_d;
      query_seen_q    <= query_seen_d;
      pend_cnt_q      <= pend_cnt_d;
      len_q           <= len_d;
      cnt_q           <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrlf_emit.sv =====
// hrlf_emit: holding slot and output shift register for the feature run
// sends the 14 features of a finished header one beat at a time
// depends on hrlf_pkg
`default_nettype none

module hrlf_emit import hrlf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      snap_valid_i,
  output logic           snap_ready_o,
  input  wire feat_vec_t snap_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_beat_o
);

  logic       hold_valid_q, hold_valid_d;
  feat_vec_t  hold_q, hold_d;
  logic       busy_q, busy_d;
  logic [3:0] idx_q, idx_d;
  feat_vec_t  sh_q, sh_d;
  logic       out_fire, is_last, load, snap_fire;

  assign snap_ready_o = !hold_valid_q;
  assign snap_fire    = snap_valid_i && !hold_valid_q;
  assign out_fire     = busy_q && out_ready_i;
  assign is_last      = (idx_q == LAST_IDX);
  assign load         = hold_valid_q && (!busy_q || (out_fire && is_last));

  always_comb begin
    hold_valid_d = snap_fire || (hold_valid_q && !load);
    hold_d       = snap_fire ? snap_i : hold_q;
    busy_d       = busy_q;
    idx_d        = idx_q;
    sh_d         = sh_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 4'd0;
      sh_d   = hold_q;
    end else if (out_fire) begin
      if (is_last) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + 4'd1;
      for (int j = 0; j < FEATURE_COUNT - 1; j++) sh_d[j] = sh_q[j+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      busy_q       <= 1'b0;
      idx_q        <= 4'd0;
    end else begin
      hold_valid_q <= hold_valid_d;
      busy_q       <= busy_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    sh_q   <= sh_d;
  end

  assign out_valid_o              = busy_q;
  assign out_beat_o.feature_index = idx_q;
  assign out_beat_o.feature_value = sh_q[0];
  assign out_beat_o.last_feature  = is_last;

endmodule

`default_nettype wire

// ===== rtl/core/http_request_line_fingerprint_unit.sv =====
// http_request_line_fingerprint_unit: top level of the request line fingerprint
// joins the byte scanner and the feature emitter
// depends on hrlf_pkg, hrlf_scan, hrlf_emit
//
// usage:
//   input channel carries one header byte per beat plus an end_of_header flag on
//   the last byte of a header. only the request line (bytes before the first cr
//   or lf) is scanned; every byte counts toward the length.
//   output channel carries the 14 features of a header, index 0 to 13, with
//   last_feature set on index 13.
// timing:
//   one input beat per cycle while in_ready_o is high. each beat sits in the input
//   register while the scan logic updates the header state. the first feature of a
//   header goes out from the input register via the holding slot and the shift register;
//   the others follow one per cycle while out_ready_i is high.
//   one finished header can wait in a holding slot while the previous run is
//   still draining, so headers of 14 bytes or more stream at one byte per cycle.
//   shorter headers, or a stalled receiver, fill the holding slot and then the
//   input register, and in_ready_o drops until the emitter frees the slot.
// reset:
//   clears all header state (method and version back to none, counts and length
//   to zero), empties the input register, the holding slot and the emitter.
`default_nettype none

module http_request_line_fingerprint_unit import hrlf_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_beat_t     out_beat_o
);

  // finished header snapshot from scanner to emitter
  logic      snap_valid;
  logic      snap_ready;
  feat_vec_t snap;

  hrlf_scan #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // holding slot plus shift register, one feature per beat
  hrlf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_beat_o   (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hrlf_checker.sv =====
// hrlf_checker: port-level checks for the fingerprint unit, bound to the top
// watches input beat holding and the ordering of the feature run on the output channel
// depends on hrlf_pkg, http_request_line_fingerprint_unit
`default_nettype none

module hrlf_checker import hrlf_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_beat_t  in_beat_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_beat_o
);

  // a waiting input beat holds until accepted
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_beat_i))
    else $error("input beat changed while waiting");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // the run ends on the fourteenth feature only
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.last_feature == (out_beat_o.feature_index == LAST_IDX)))
    else $error("last_feature not on the final index");

  // inside a run, indices advance by one with no gap
  a_next_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_beat_o.last_feature |=>
      out_valid_o && out_beat_o.feature_index == $past(out_beat_o.feature_index) + 4'd1)
    else $error("feature run broken");

  // a new run starts at index zero
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_beat_o.last_feature |=>
      !out_valid_o || out_beat_o.feature_index == 4'd0)
    else $error("feature run does not start at method");

endmodule

bind http_request_line_fingerprint_unit hrlf_checker u_hrlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
